/* rtl/dws_pkg.sv */
// Shared constants, codes and ring index helpers for the searchable deque.
package dws_pkg;

	localparam int CAPACITY  = 256;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 8;
	localparam int COUNT_W   = 9;

	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIND       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_LENGTH     = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Fold a sum of two ring indexes (each below CAPACITY) back into the ring.
	function automatic idx_t ring_wrap(input logic [IDX_W:0] sum);
		logic [IDX_W:0] cap;
		cap = (IDX_W + 1)'(CAPACITY);
		ring_wrap = (sum >= cap) ? IDX_W'(sum - cap) : IDX_W'(sum);
	endfunction

	// Step one slot forward, wrapping at the end of the ring.
	function automatic idx_t ring_inc(input idx_t idx);
		ring_inc = (idx == IDX_W'(CAPACITY - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

	// Step one slot back, wrapping at the start of the ring.
	function automatic idx_t ring_dec(input idx_t idx);
		ring_dec = (idx == '0) ? IDX_W'(CAPACITY - 1) : idx - IDX_W'(1);
	endfunction

endpackage

/* rtl/dws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/deque_with_search_core.sv */
// Searchable double-ended queue of 32-bit words kept in a ring RAM.
//
// A bounded deque of CAPACITY signed 32-bit words held in a ring store. Each
// accepted word carries one operation (push back, push front, pop back, pop
// front, find, length) and yields exactly one result word with a status, a
// match position and the count held after the operation. Pushes, pops, length
// and a find on an empty queue finish in the cycle they are accepted and
// their result is registered at that edge. A find on a non-empty queue walks
// the held entries from the front through the single read port of the ring
// RAM, one entry per cycle, comparing each against the key on one shared
// 32-bit comparator, and stops at the first match or the last held entry;
// in_stall stays high throughout the walk. A new operation is also held off
// while a result sits in the output register under out_stall. The RAM needs
// no clearing pass: only entries written by a push are ever read.
module deque_with_search_core
	import dws_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [KIND_W-1:0]          kind,
	input  logic signed [WORD_W-1:0]   data_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [POS_W-1:0]           found_position,
	output logic [COUNT_W-1:0]         entry_count
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_SEARCH = 1'b1;

	logic state_q;
	idx_t front_q;
	cnt_t cnt_q;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    pos_q;
	logic [COUNT_W-1:0]  count_q;

	// search sequencer
	logic [WORD_W-1:0] key_q;
	idx_t              addr_q;
	cnt_t              iss_q;
	logic              rd_vld_s1;
	idx_t              pos_s1;

	logic              accept;
	logic              full;
	logic              empty;
	idx_t              back_slot;
	idx_t              front_prev;
	logic              wr_en;
	idx_t              wr_addr;
	logic              rd_en;
	logic [WORD_W-1:0] rd_data;
	logic              hit;
	logic              last;

	assign full  = (cnt_q == CNT_W'(CAPACITY));
	assign empty = (cnt_q == '0);

	// Hold input while searching or while the last result is still unclaimed.
	assign in_stall = (state_q == S_SEARCH) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign back_slot  = ring_wrap({1'b0, front_q} + (IDX_W + 1)'(cnt_q));
	assign front_prev = ring_dec(front_q);

	// Pushes write the RAM at the edge they are accepted.
	assign wr_en   = accept && !full && (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT);
	assign wr_addr = (kind == KIND_PUSH_FRONT) ? front_prev : back_slot;

	// Compare the word read last cycle; stop on the first match or the last entry.
	assign hit   = rd_vld_s1 && (rd_data == key_q);
	assign last  = rd_vld_s1 && ((CNT_W'(pos_s1) + CNT_W'(1)) == cnt_q);
	assign rd_en = (state_q == S_SEARCH) && (iss_q < cnt_q) && !hit;

	dws_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (data_value),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// Control state: sequencer, ring pointers, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == KIND_FIND && !empty) begin
							// Walk the ring; the result comes out at the end.
							state_q <= S_SEARCH;
						end else begin
							out_valid_q <= 1'b1;
						end
						unique case (kind)
							KIND_PUSH_BACK: begin
								if (!full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							KIND_PUSH_FRONT: begin
								if (!full) begin
									front_q <= front_prev;
									cnt_q   <= cnt_q + CNT_W'(1);
								end
							end
							KIND_POP_BACK: begin
								if (!empty) begin
									cnt_q <= cnt_q - CNT_W'(1);
								end
							end
							KIND_POP_FRONT: begin
								if (!empty) begin
									front_q <= ring_inc(front_q);
									cnt_q   <= cnt_q - CNT_W'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit || last) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						rd_vld_s1   <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: result word, search key and read pointers.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_q <= ring_inc(addr_q);
			iss_q  <= iss_q + CNT_W'(1);
			pos_s1 <= IDX_W'(iss_q);
		end
		if (state_q == S_IDLE && accept) begin
			key_q  <= data_value;
			addr_q <= front_q;
			iss_q  <= '0;
			pos_q  <= '0;
			unique case (kind)
				KIND_PUSH_BACK: begin
					status_q <= full ? ST_FULL : ST_OK;
					count_q  <= full ? COUNT_W'(cnt_q) : COUNT_W'(cnt_q + CNT_W'(1));
				end
				KIND_PUSH_FRONT: begin
					status_q <= full ? ST_FULL : ST_OK;
					count_q  <= full ? COUNT_W'(cnt_q) : COUNT_W'(cnt_q + CNT_W'(1));
				end
				KIND_POP_BACK: begin
					status_q <= empty ? ST_EMPTY : ST_OK;
					count_q  <= empty ? COUNT_W'(cnt_q) : COUNT_W'(cnt_q - CNT_W'(1));
				end
				KIND_POP_FRONT: begin
					status_q <= empty ? ST_EMPTY : ST_OK;
					count_q  <= empty ? COUNT_W'(cnt_q) : COUNT_W'(cnt_q - CNT_W'(1));
				end
				KIND_FIND: begin
					status_q <= ST_EMPTY;
					count_q  <= COUNT_W'(cnt_q);
				end
				default: begin
					// length and unused codes
					status_q <= ST_OK;
					count_q  <= COUNT_W'(cnt_q);
				end
			endcase
		end
		if (state_q == S_SEARCH && (hit || last)) begin
			status_q <= hit ? ST_OK : ST_NOT_FOUND;
			pos_q    <= hit ? POS_W'(pos_s1) : '0;
			count_q  <= COUNT_W'(cnt_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_position = pos_q;
	assign entry_count    = count_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("held count exceeds capacity");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= IDX_W'(CAPACITY - 1))
		else $error("front index outside ring");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CNT_W'(pos_s1) < cnt_q))
		else $error("search read beyond held entries");

	a_find_enters_search: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_FIND && !empty) |=> (state_q == S_SEARCH && !out_valid_q))
		else $error("find on non-empty queue did not start a search");
`endif

endmodule

/* bench/tb_deque_with_search_core.sv */
// Testbench for the searchable deque: directed and random words checked against a mirror.
`timescale 1ns / 100ps
module tb_deque_with_search_core;
	import dws_pkg::*;

	// Kind codes the block does not name; both behave like a length query.
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	// Cycles with no word moving on either side before the run is abandoned.
	localparam int QUIET_LIMIT = 4000;
	// Marker pushed last into the full queue so a find must walk to the far end.
	localparam logic signed [WORD_W-1:0] DEEP_MARKER = 32'sh7FFF_FFFE;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [COUNT_W-1:0]  count;
	} deque_result_t;

	// Mirror of the deque: holds its own ring, front slot and fill, and the
	// results still owed by the block, oldest first.
	class deque_mirror;
		logic signed [WORD_W-1:0] ring_words [CAPACITY];
		idx_t                     head;
		cnt_t                     held;
		deque_result_t            owed[$];
		int                       errors;

		function new();
			head   = '0;
			held   = '0;
			errors = 0;
		endfunction

		function idx_t slot(int offset);
			return idx_t'((int'(head) + offset) % CAPACITY);
		endfunction

		function logic signed [WORD_W-1:0] held_word(int offset);
			return ring_words[slot(offset)];
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Apply one accepted operation and queue the result it must give.
		function void note_word(logic [KIND_W-1:0] op, logic signed [WORD_W-1:0] word);
			deque_result_t r;
			int            pos;
			r        = '0;
			pos      = 0;
			r.status = ST_OK;
			case (op)
				KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
					if (held == cnt_t'(CAPACITY)) begin
						r.status = ST_FULL;
					end else if (op == KIND_PUSH_FRONT) begin
						head             = slot(CAPACITY - 1);
						ring_words[head] = word;
						held++;
					end else begin
						ring_words[slot(int'(held))] = word;
						held++;
					end
				end
				KIND_POP_BACK: begin
					if (held == 0) r.status = ST_EMPTY;
					else held--;
				end
				KIND_POP_FRONT: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						head = slot(1);
						held--;
					end
				end
				KIND_FIND: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.status = ST_NOT_FOUND;
						for (int i = 0; i < held; i++) begin
							if (ring_words[slot(i)] == word) begin
								r.status = ST_OK;
								pos      = i;
								break;
							end
						end
					end
				end
				default: begin
				end
			endcase
			r.position = POS_W'(pos);
			r.count    = COUNT_W'(held);
			owed.push_back(r);
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("%0t: %s differs: got %0h, expected %0h", $time, field, got, want);
			errors++;
		endtask

		// Compare one accepted result word with the oldest owed result.
		task check_result(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos,
				logic [COUNT_W-1:0] cnt);
			deque_result_t want;
			if (owed.size() == 0) begin
				report("result with nothing owed, status", 32'(st), '0);
				return;
			end
			want = owed.pop_front();
			if (st !== want.status) report("status", 32'(st), 32'(want.status));
			if (pos !== want.position) report("found_position", 32'(pos), 32'(want.position));
			if (cnt !== want.count) report("entry_count", 32'(cnt), 32'(want.count));
		endtask
	endclass

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic [KIND_W-1:0]        kind       = '0;
	logic signed [WORD_W-1:0] data_value = '0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic [POS_W-1:0]         found_position;
	logic [COUNT_W-1:0]       entry_count;

	int          send_idle_pct = 29;
	int          recv_idle_pct = 60;
	int          quiet_cycles  = 0;
	deque_mirror mirror        = new();

	deque_with_search_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.data_value     (data_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall the result port at random, at the current idle rate.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Check each result word as it leaves, and watch for a hung block: any
	// word moving on either side restarts the quiet count.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			mirror.check_result(status, found_position, entry_count);
		end
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offer one operation word, idling first at the current sender rate, and
	// hold it steady until the block takes it; then update the mirror.
	task automatic send_word(input logic [KIND_W-1:0] op, input logic signed [WORD_W-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= op;
		data_value <= word;
		do begin
			@(posedge clk);
		end while (!(in_valid && !in_stall));
		mirror.note_word(op, word);
	endtask

	// Hold off the sender until every owed result has come back.
	task automatic wait_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (mirror.pending() != 0);
	endtask

	// Half full-range values, half a narrow band so duplicates and hits occur.
	function automatic logic signed [WORD_W-1:0] pick_word();
		if ($urandom_range(1) != 0) return $urandom;
		return WORD_W'($urandom_range(15) - 8);
	endfunction

	// Search key: when the queue holds words, half the time one of them; otherwise anything.
	function automatic logic signed [WORD_W-1:0] pick_key();
		if (mirror.held != 0 && $urandom_range(1) != 0) begin
			return mirror.held_word($urandom_range(int'(mirror.held) - 1));
		end
		return pick_word();
	endfunction

	// Random mix biased toward pushes so the queue grows and the front wraps.
	task automatic random_burst(input int items);
		int roll;
		repeat (items) begin
			roll = $urandom_range(99);
			if (roll < 30) send_word(KIND_PUSH_BACK, pick_word());
			else if (roll < 55) send_word(KIND_PUSH_FRONT, pick_word());
			else if (roll < 67) send_word(KIND_POP_BACK, pick_word());
			else if (roll < 79) send_word(KIND_POP_FRONT, pick_word());
			else if (roll < 91) send_word(KIND_FIND, pick_key());
			else if (roll < 96) send_word(KIND_LENGTH, pick_word());
			else send_word(($urandom_range(1) != 0) ? KIND_SPARE_A : KIND_SPARE_B, $urandom);
		end
	endtask

	// Fill the queue to capacity from both ends, hit it while full, search its
	// far end, then drain it from both ends and pop past empty.
	task automatic fill_and_drain();
		while (mirror.held < CAPACITY - 1) begin
			if ($urandom_range(9) == 0) begin
				send_word(KIND_FIND, pick_key());
			end else begin
				send_word(($urandom_range(1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
					pick_word());
			end
		end
		send_word(KIND_PUSH_BACK, DEEP_MARKER);
		send_word(KIND_PUSH_BACK, pick_word());
		send_word(KIND_PUSH_FRONT, pick_word());
		send_word(KIND_FIND, DEEP_MARKER);
		send_word(KIND_FIND, mirror.held_word(0));
		send_word(KIND_FIND, $urandom);
		send_word(KIND_LENGTH, pick_word());
		while (mirror.held != 0) begin
			if ($urandom_range(11) == 0) begin
				send_word(KIND_FIND, pick_key());
			end else begin
				send_word(($urandom_range(1) != 0) ? KIND_POP_FRONT : KIND_POP_BACK,
					pick_word());
			end
		end
		send_word(KIND_POP_FRONT, pick_word());
		send_word(KIND_POP_BACK, pick_word());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty queue, spare kinds, extreme values, front wrap,
		// hits, misses and duplicates.
		send_word(KIND_POP_BACK, 32'sh0000_0000);
		send_word(KIND_POP_FRONT, 32'shFFFF_FFFF);
		send_word(KIND_FIND, 32'sh0000_0000);
		send_word(KIND_LENGTH, 32'shFFFF_FFFF);
		send_word(KIND_SPARE_A, 32'sh5555_5555);
		send_word(KIND_SPARE_B, 32'shAAAA_AAAA);
		send_word(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
		send_word(KIND_PUSH_BACK, 32'sh8000_0000);
		send_word(KIND_PUSH_FRONT, 32'sh0000_0000);
		send_word(KIND_PUSH_FRONT, 32'shFFFF_FFFF);
		send_word(KIND_FIND, 32'sh8000_0000);
		send_word(KIND_FIND, 32'shFFFF_FFFF);
		send_word(KIND_FIND, 32'sh0001_2345);
		send_word(KIND_FIND, 32'sh7FFF_FFFF);
		send_word(KIND_LENGTH, 32'sh0000_0000);
		send_word(KIND_POP_BACK, 32'sh0000_0000);
		send_word(KIND_POP_FRONT, 32'sh0000_0000);
		send_word(KIND_FIND, 32'sh7FFF_FFFF);
		send_word(KIND_PUSH_BACK, 32'sh0000_0000);
		send_word(KIND_FIND, 32'sh0000_0000);
		send_word(KIND_POP_FRONT, 32'sh0000_0000);
		send_word(KIND_POP_FRONT, 32'sh0000_0000);
		send_word(KIND_POP_FRONT, 32'sh0000_0000);
		send_word(KIND_FIND, 32'sh0000_0000);
		send_word(KIND_SPARE_B, 32'sh0000_0000);

		random_burst(90);
		wait_results();

		// Swap the idle rates: slow sender, busy receiver.
		send_idle_pct = 60;
		recv_idle_pct = 29;
		fill_and_drain();
		wait_results();

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_burst(90);

		// Drain, then idle on so that any stray result word surfaces.
		wait_results();
		repeat (CAPACITY + 4) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
